FILE: design/asca_pkg.sv
// Package for the SGR-to-console-attribute block.
// Holds character codes, mode and prefix codes, the state record and the colour remap.
// No dependencies.
package asca_pkg;

  localparam logic [7:0] CH_M     = 8'h6D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_THREE = 8'h33;
  localparam logic [7:0] CH_FOUR  = 8'h34;
  localparam logic [7:0] CH_SEVEN = 8'h37;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SEMI  = 8'h3B;

  localparam logic [2:0] COLOR_WHITE = 3'd7;
  localparam logic [2:0] COLOR_BLACK = 3'd0;

  localparam logic [1:0] MODE_NORMAL  = 2'd0;
  localparam logic [1:0] MODE_BOLD    = 2'd1;
  localparam logic [1:0] MODE_INVERSE = 2'd2;

  localparam logic [1:0] PEND_NONE = 2'd0;
  localparam logic [1:0] PEND_FORE = 2'd1;
  localparam logic [1:0] PEND_BACK = 2'd2;

  localparam logic [2:0] COLOR_REMAP [8] = '{3'd0, 3'd4, 3'd2, 3'd6, 3'd1, 3'd5, 3'd3, 3'd7};

  typedef struct packed {
    logic [7:0] char_in;
    logic       seq_start;
  } req_t;

  typedef struct packed {
    logic [6:0] text_attribute;
  } rsp_t;

  typedef struct packed {
    logic [2:0] fore_color;
    logic [2:0] back_color;
    logic [1:0] style_mode;
    logic [1:0] pending_prefix;
  } attr_state_t;

endpackage

FILE: design/asca_stream_if.sv
// Valid/ready stream interface used on both channels of the SGR block.
// Payload type comes from asca_pkg.
interface asca_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: design/ansi_sgr_to_console_attribute.sv
// Top level of the SGR-to-console-attribute block: input register, byte
// interpreter and result register. Depends on asca_pkg, asca_stream_if, asca_sgr_decode.
//
//   channel  dir  payload                       handshake
//   req      in   char_in[7:0], seq_start       valid/ready
//   rsp      out  text_attribute[6:0]           valid/ready
//   cfg      in   cfg_wr_data (output_enable)   cfg_wr_en, no wait
//
// One byte per cycle while rsp accepts results; each accepted byte waits in the input
// register, then takes one interpreter pass, and only a terminator writes the result register.
// The colour/mode state updates in the same pass, so each byte sees the last.
// rst (synchronous) empties both registers and returns state to white on black,
// normal mode, no pending prefix, output enabled.
// A stalled rsp holds the byte in the input register; req.ready then drops.
module ansi_sgr_to_console_attribute (
  input  logic                 clk,
  input  logic                 rst,
  asca_stream_if.sink          req,
  asca_stream_if.source        rsp,
  input  logic                 cfg_wr_en,
  input  logic                 cfg_wr_data
);

  // input register
  logic       s1_valid;
  logic [7:0] s1_char;
  logic       s1_start;

  // block state and configuration
  asca_pkg::attr_state_t state;
  asca_pkg::attr_state_t state_next;
  logic                  output_enable;

  // result register
  logic       rsp_valid;
  logic [6:0] rsp_attr;

  logic       emit;
  logic [6:0] attr_next;
  logic       fire;
  logic       req_fire;

  // the interpreted byte leaves the input register once the result slot is free
  assign fire     = s1_valid && (!rsp_valid || rsp.ready);
  assign req.ready = !s1_valid || fire;
  assign req_fire = req.valid && req.ready;

  asca_sgr_decode u_decode (
    .state          (state),
    .char_in        (s1_char),
    .seq_start      (s1_start),
    .state_next     (state_next),
    .emit           (emit),
    .text_attribute (attr_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      s1_char  <= req.payload.char_in;
      s1_start <= req.payload.seq_start;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      output_enable <= 1'b1;
    end else if (cfg_wr_en) begin
      output_enable <= cfg_wr_data;
    end
  end

  // while disabled, bytes are consumed with no effect at all
  always_ff @(posedge clk) begin
    if (rst) begin
      state.fore_color     <= asca_pkg::COLOR_WHITE;
      state.back_color     <= asca_pkg::COLOR_BLACK;
      state.style_mode     <= asca_pkg::MODE_NORMAL;
      state.pending_prefix <= asca_pkg::PEND_NONE;
    end else if (fire && output_enable) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (fire) begin
      rsp_valid <= emit && output_enable;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit && output_enable) begin
      rsp_attr <= attr_next;
    end
  end

  assign rsp.valid                  = rsp_valid;
  assign rsp.payload.text_attribute = rsp_attr;

  a_emit_shows: assert property (@(posedge clk) disable iff (rst)
    (fire && emit && output_enable) |=> rsp.valid)
    else $error("terminator did not produce a result");

  a_disabled_frozen: assert property (@(posedge clk) disable iff (rst)
    (fire && !output_enable) |=> $stable(state))
    else $error("state changed while output disabled");

  a_prefix_code: assert property (@(posedge clk) disable iff (rst)
    state.pending_prefix != 2'b11)
    else $error("invalid pending prefix code");

  a_no_spurious_rsp: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(fire && emit && output_enable))
    else $error("result appeared without a terminator");

endmodule

FILE: design/asca_sgr_decode.sv
// Combinational SGR byte interpreter: current state and one byte in, next state
// and an optional attribute out. Depends on asca_pkg.
module asca_sgr_decode (
  input  asca_pkg::attr_state_t state,
  input  logic [7:0]            char_in,
  input  logic                  seq_start,
  output asca_pkg::attr_state_t state_next,
  output logic                  emit,
  output logic [6:0]            text_attribute
);

  logic       digit;
  logic [1:0] pend;
  logic [1:0] mode_base;
  logic [7:0] d;
  logic [2:0] f;
  logic [2:0] b;

  assign digit = (char_in >= asca_pkg::CH_ZERO) && (char_in <= asca_pkg::CH_NINE);
  assign pend  = seq_start ? asca_pkg::PEND_NONE : state.pending_prefix;
  assign d     = char_in - asca_pkg::CH_ZERO;
  // a lone prefix clears the mode before the byte is taken on its own
  assign mode_base = (pend != asca_pkg::PEND_NONE) ? asca_pkg::MODE_NORMAL : state.style_mode;

  assign f = state.fore_color;
  assign b = state.back_color;

  always_comb begin
    state_next                = state;
    state_next.pending_prefix = asca_pkg::PEND_NONE;
    state_next.style_mode     = mode_base;
    emit                      = 1'b0;
    text_attribute            = {b, 1'b0, f};
    if (pend != asca_pkg::PEND_NONE && digit) begin
      state_next.style_mode = state.style_mode;
      if (pend == asca_pkg::PEND_FORE) begin
        state_next.fore_color = (d > 8'd7) ? asca_pkg::COLOR_WHITE : asca_pkg::COLOR_REMAP[d[2:0]];
      end else begin
        state_next.back_color = (d > 8'd7) ? asca_pkg::COLOR_BLACK : asca_pkg::COLOR_REMAP[d[2:0]];
      end
    end else begin
      case (char_in)
        asca_pkg::CH_M: begin
          emit = 1'b1;
          if (mode_base == asca_pkg::MODE_INVERSE) begin
            text_attribute = {f, 1'b0, b};
          end else begin
            text_attribute = {b, mode_base == asca_pkg::MODE_BOLD, f};
          end
        end
        asca_pkg::CH_THREE: state_next.pending_prefix = asca_pkg::PEND_FORE;
        asca_pkg::CH_FOUR:  state_next.pending_prefix = asca_pkg::PEND_BACK;
        asca_pkg::CH_SEMI:  ;
        asca_pkg::CH_ZERO: begin
          state_next.style_mode = asca_pkg::MODE_NORMAL;
          if (seq_start) begin
            state_next.fore_color = asca_pkg::COLOR_WHITE;
            state_next.back_color = asca_pkg::COLOR_BLACK;
          end
        end
        asca_pkg::CH_ONE:   state_next.style_mode = asca_pkg::MODE_BOLD;
        asca_pkg::CH_SEVEN: state_next.style_mode = asca_pkg::MODE_INVERSE;
        default:            state_next.style_mode = asca_pkg::MODE_NORMAL;
      endcase
    end
  end

endmodule
